FILE: hw/rtl/bsr_pkg.sv
// Shared types and constants of the box screen rectangle block.
// Used by bsr_div and box_screen_rectangle; depends on nothing.
`default_nettype none

package bsr_pkg;

  // default parameter values
  localparam int MAX_VIEWPORT_DEF = 4096;
  localparam int FRAC_BITS_DEF    = 16;

  // integer bits of a normalized coordinate; magnitude saturates at 2^NDC_INT_BITS
  localparam int NDC_INT_BITS = 15;

  // operation selector carried in tuser
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] CFG_WIDTH    = 2'd2;
  localparam logic [1:0] CFG_HEIGHT   = 2'd3;

  localparam logic signed [12:0] ORIGIN_RESET = 13'sd0;
  localparam logic [12:0]        WIDTH_RESET  = 13'd1920;
  localparam logic [12:0]        HEIGHT_RESET = 13'd1080;

  // box corners, walked in order 0..7
  localparam logic [2:0] FIRST_CORNER = 3'd0;
  localparam logic [2:0] LAST_CORNER  = 3'd7;

  // per-corner control traveling with the data
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic fault;
  } tag_t;

endpackage

`default_nettype wire

FILE: hw/rtl/box_screen_rectangle.sv
// Top level of the box screen rectangle block: corner sequencer, transform,
// viewport mapping, min/max and clamp. Depends on bsr_pkg and bsr_div.
//
// Use: a request on the slave stream either loads one element of the 4x4
// transform (tuser = load) or projects a box (tuser = project). A load yields
// no result. A box is walked corner by corner, one corner per cycle through
// the transform unless the receiver stalls; the next request is taken
// once the eighth corner has been issued. Each box yields one result on the
// master stream; the divider yields one quotient bit per stage. Boxes stream
// back to back: a new box is taken while earlier ones are still in flight.
// Loads behind a box take effect only for later boxes.
// Configuration writes take effect at once; the user must make them only
// while idle, as the block itself does not enforce this. Reset clears all
// valid bits and returns the configuration registers to their reset values;
// the matrix holds no defined value until written. When the receiver stalls,
// the whole pipeline holds: nothing is lost or repeated, and no request is
// taken while a result waits on the master stream.
`default_nettype none

module box_screen_rectangle #(
  parameter int MAX_VIEWPORT = bsr_pkg::MAX_VIEWPORT_DEF,
  parameter int FRAC_BITS    = bsr_pkg::FRAC_BITS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // configuration write port
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_idx_i,
  input  wire  [12:0] cfg_wdata_i,
  // requests
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // element_index, element_value, box_min_x, box_min_y, box_min_z,
  // box_max_x, box_max_y, box_max_z, zero fill
  input  wire  [231:0] s_axis_tdata,
  // operation
  input  wire  [0:0]  s_axis_tuser,
  // results
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // rect_x, rect_y, rect_w, rect_h
  output logic [47:0] m_axis_tdata,
  // depth_fault
  output logic [0:0]  m_axis_tuser
);
  import bsr_pkg::*;

  localparam int CLIPW = 66 - FRAC_BITS;
  localparam int QB    = NDC_INT_BITS + FRAC_BITS;
  localparam int NW    = QB + 2;
  localparam int SZW   = $clog2(MAX_VIEWPORT + 1);
  localparam int PMW   = NW + SZW + 1;
  localparam int SXW   = PMW + 2;
  localparam int CLW   = SZW + FRAC_BITS;

  // matrix rows used: x, y and w (z is never needed)
  function automatic logic [1:0] row_sel(int j);
    return (j == 2) ? 2'd3 : 2'(j);
  endfunction

  // ---------------------------------------------------------------- config
  logic signed [12:0] org_x_q, org_y_q;
  logic [12:0]        vw_q, vh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= ORIGIN_RESET;
      org_y_q <= ORIGIN_RESET;
      vw_q    <= WIDTH_RESET;
      vh_q    <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ORIGIN_X: org_x_q <= $signed(cfg_wdata_i);
        CFG_ORIGIN_Y: org_y_q <= $signed(cfg_wdata_i);
        CFG_WIDTH:    vw_q    <= cfg_wdata_i;
        CFG_HEIGHT:   vh_q    <= cfg_wdata_i;
        default:      ;
      endcase
    end
  end

  // effective viewport size: zero acts as one, oversize acts as the maximum
  logic [SZW-1:0] ew, eh;
  always_comb begin
    if (vw_q == '0) ew = SZW'(1);
    else if (32'(vw_q) > MAX_VIEWPORT) ew = SZW'(MAX_VIEWPORT);
    else ew = SZW'(vw_q);
    if (vh_q == '0) eh = SZW'(1);
    else if (32'(vh_q) > MAX_VIEWPORT) eh = SZW'(MAX_VIEWPORT);
    else eh = SZW'(vh_q);
  end

  // ---------------------------------------------------------------- handshake
  logic out_v_q;
  logic adv;
  logic busy_q;
  logic [2:0] cnt_q;
  logic s_acc;

  assign adv           = !out_v_q || m_axis_tready;
  assign s_axis_tready = adv && !busy_q;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  logic               in_op;
  logic [3:0]         in_idx;
  logic signed [31:0] in_val;
  logic signed [31:0] in_box [6];

  assign in_op  = s_axis_tuser[0];
  assign in_idx = s_axis_tdata[3:0];
  assign in_val = $signed(s_axis_tdata[35:4]);
  for (genvar i = 0; i < 6; i++) begin : g_unpack
    assign in_box[i] = $signed(s_axis_tdata[36 + 32*i +: 32]);
  end

  // ---------------------------------------------------------------- matrix
  logic signed [31:0] mat_q [16];

  always_ff @(posedge clk_i) begin
    if (s_acc && in_op == OP_LOAD) mat_q[in_idx] <= in_val;
  end

  // ---------------------------------------------------------------- corner walk
  logic signed [31:0] box_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= FIRST_CORNER;
    end else if (adv) begin
      if (s_acc && in_op == OP_PROJECT) begin
        busy_q <= 1'b1;
        cnt_q  <= FIRST_CORNER + 3'd1;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == LAST_CORNER) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc && in_op == OP_PROJECT) begin
      for (int i = 0; i < 6; i++) box_q[i] <= in_box[i];
    end
  end

  // corner 0 comes straight from the request, the rest from the held box
  logic               iss_v;
  logic [2:0]         corner;
  logic signed [31:0] pt [3];

  always_comb begin
    iss_v  = (s_acc && in_op == OP_PROJECT) || busy_q;
    corner = busy_q ? cnt_q : FIRST_CORNER;
    for (int c = 0; c < 3; c++) begin
      if (busy_q) pt[c] = corner[c] ? box_q[3+c] : box_q[c];
      else        pt[c] = in_box[c];
    end
  end

  // ---------------------------------------------------------------- stage 1: products
  logic               v1_q, first1_q, last1_q;
  logic signed [63:0] prod_q [9];
  logic signed [31:0] trans_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= iss_v;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      first1_q <= (corner == FIRST_CORNER);
      last1_q  <= (corner == LAST_CORNER);
      for (int j = 0; j < 3; j++) begin
        trans_q[j] <= mat_q[{row_sel(j), 2'd3}];
        for (int c = 0; c < 3; c++) prod_q[j*3+c] <= mat_q[{row_sel(j), 2'(c)}] * pt[c];
      end
    end
  end

  // ---------------------------------------------------------------- stage 2: clip sums
  logic                    v2_q, first2_q, last2_q;
  logic signed [CLIPW-1:0] clip_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      first2_q <= first1_q;
      last2_q  <= last1_q;
      // floor each product to the fraction, then sum exactly
      for (int j = 0; j < 3; j++) begin
        clip_q[j] <= CLIPW'(trans_q[j])
                   + CLIPW'(prod_q[j*3+0] >>> FRAC_BITS)
                   + CLIPW'(prod_q[j*3+1] >>> FRAC_BITS)
                   + CLIPW'(prod_q[j*3+2] >>> FRAC_BITS);
      end
    end
  end

  // ---------------------------------------------------------------- divide by w
  tag_t              div_tag_in, div_tag;
  logic signed [NW-1:0] ndc_x, ndc_y;

  always_comb begin
    div_tag_in.valid = v2_q;
    div_tag_in.first = first2_q;
    div_tag_in.last  = last2_q;
    div_tag_in.fault = (clip_q[2] <= 0);
  end

  bsr_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .tag_i   (div_tag_in),
    .num_x_i (clip_q[0]),
    .num_y_i (clip_q[1]),
    .den_i   (clip_q[2]),
    .tag_o   (div_tag),
    .ndc_x_o (ndc_x),
    .ndc_y_o (ndc_y)
  );

  // ---------------------------------------------------------------- scale by size
  tag_t                 tag_m_q;
  logic signed [PMW-1:0] pm_x_q, pm_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tag_m_q <= '0;
    else if (adv) tag_m_q <= div_tag;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pm_x_q <= ndc_x * $signed({1'b0, ew});
      pm_y_q <= ndc_y * $signed({1'b0, eh});
    end
  end

  // ---------------------------------------------------------------- half, center, origin
  tag_t                  tag_s_q;
  logic signed [SXW-1:0] sx_q, sy_q;
  logic signed [SXW-1:0] half_x, half_y;

  always_comb begin
    half_x = SXW'(pm_x_q) + SXW'($signed({1'b0, ew, {FRAC_BITS{1'b0}}}));
    half_y = SXW'(pm_y_q) + SXW'($signed({1'b0, eh, {FRAC_BITS{1'b0}}}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tag_s_q <= '0;
    else if (adv) tag_s_q <= tag_m_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sx_q <= (half_x >>> 1) + SXW'($signed({org_x_q, {FRAC_BITS{1'b0}}}));
      sy_q <= (half_y >>> 1) + SXW'($signed({org_y_q, {FRAC_BITS{1'b0}}}));
    end
  end

  // ---------------------------------------------------------------- min/max over corners
  logic signed [SXW-1:0] acc_q [4];   // min x, max x, min y, max y
  logic                  acc_fault_q;
  logic signed [SXW-1:0] nxt [4];
  logic                  nxt_fault;

  always_comb begin
    logic keep;
    keep = tag_s_q.first || !tag_s_q.fault;
    nxt[0] = (tag_s_q.first || (keep && sx_q < acc_q[0])) ? sx_q : acc_q[0];
    nxt[1] = (tag_s_q.first || (keep && sx_q > acc_q[1])) ? sx_q : acc_q[1];
    nxt[2] = (tag_s_q.first || (keep && sy_q < acc_q[2])) ? sy_q : acc_q[2];
    nxt[3] = (tag_s_q.first || (keep && sy_q > acc_q[3])) ? sy_q : acc_q[3];
    nxt_fault = tag_s_q.fault || (!tag_s_q.first && acc_fault_q);
  end

  logic                  vf_q;
  logic signed [SXW-1:0] fin_q [4];
  logic                  fin_fault_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vf_q <= 1'b0;
    else if (adv) vf_q <= tag_s_q.valid && tag_s_q.last;
  end

  always_ff @(posedge clk_i) begin
    if (adv && tag_s_q.valid) begin
      for (int i = 0; i < 4; i++) acc_q[i] <= nxt[i];
      acc_fault_q <= nxt_fault;
    end
    if (adv) begin
      for (int i = 0; i < 4; i++) fin_q[i] <= nxt[i];
      fin_fault_q <= nxt_fault;
    end
  end

  // ---------------------------------------------------------------- clamp
  logic [CLW-1:0] lim_x, lim_y;
  logic           vc_q;
  logic [CLW-1:0] clamp_q [4];
  logic           clamp_fault_q;

  assign lim_x = {ew - 1'b1, {FRAC_BITS{1'b0}}};
  assign lim_y = {eh - 1'b1, {FRAC_BITS{1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vc_q <= 1'b0;
    else if (adv) vc_q <= vf_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        logic [CLW-1:0] lim;
        lim = (i < 2) ? lim_x : lim_y;
        if (fin_q[i][SXW-1])                       clamp_q[i] <= '0;
        else if (fin_q[i][SXW-1:0] > SXW'(lim))    clamp_q[i] <= lim;
        else                                       clamp_q[i] <= CLW'(fin_q[i]);
      end
      clamp_fault_q <= fin_fault_q;
    end
  end

  // ---------------------------------------------------------------- output register
  logic [11:0] rx_q, ry_q, rw_q, rh_q;
  logic        fault_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (adv) out_v_q <= vc_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fault_q <= clamp_fault_q;
      if (clamp_fault_q) begin
        // drop the rectangle when a corner sits behind the eye
        rx_q <= '0;
        ry_q <= '0;
        rw_q <= '0;
        rh_q <= '0;
      end else begin
        rx_q <= 12'(clamp_q[0] >> FRAC_BITS);
        ry_q <= 12'(clamp_q[2] >> FRAC_BITS);
        rw_q <= 12'((clamp_q[1] - clamp_q[0]) >> FRAC_BITS);
        rh_q <= 12'((clamp_q[3] - clamp_q[2]) >> FRAC_BITS);
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {rh_q, rw_q, ry_q, rx_q};
  assign m_axis_tuser  = fault_q;

endmodule

`default_nettype wire

FILE: hw/rtl/bsr_div.sv
// Pipelined dual restoring divider: two clip coordinates over a shared clip w.
// Depends on bsr_pkg (tag_t, NDC_INT_BITS).
`default_nettype none

module bsr_div #(
  parameter int  FRAC_BITS = bsr_pkg::FRAC_BITS_DEF,
  localparam int CLIPW     = 66 - FRAC_BITS,
  localparam int QB        = bsr_pkg::NDC_INT_BITS + FRAC_BITS,
  localparam int NW        = QB + 2
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         en_i,
  input  wire  bsr_pkg::tag_t         tag_i,
  input  wire  logic signed [CLIPW-1:0] num_x_i,
  input  wire  logic signed [CLIPW-1:0] num_y_i,
  input  wire  logic signed [CLIPW-1:0] den_i,
  output bsr_pkg::tag_t               tag_o,
  output logic signed [NW-1:0]        ndc_x_o,
  output logic signed [NW-1:0]        ndc_y_o
);
  import bsr_pkg::*;

  tag_t             tag_q [QB+1];
  logic [CLIPW-1:0] den_q [QB+1];
  tag_t             tag_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= QB; s++) tag_q[s] <= '0;
      tag_out_q <= '0;
    end else if (en_i) begin
      tag_q[0] <= tag_i;
      for (int s = 1; s <= QB; s++) tag_q[s] <= tag_q[s-1];
      tag_out_q <= tag_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0] <= den_i;
      for (int s = 1; s <= QB; s++) den_q[s] <= den_q[s-1];
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [CLIPW-1:0] rem_q [QB+1];
    logic [QB-1:0]    dvd_q [QB+1];
    logic [QB-1:0]    quo_q [QB+1];
    logic             sat_q [QB+1];
    logic             neg_q [QB+1];
    logic signed [NW-1:0] ndc_q;
    logic signed [CLIPW-1:0] num;
    logic [CLIPW-1:0] mag;
    logic [CLIPW-1:0] head;
    logic             sat;
    logic [QB:0]      res_mag;

    assign num  = (l == 0) ? num_x_i : num_y_i;
    assign mag  = num[CLIPW-1] ? (~num + 1'b1) : num;
    assign head = mag >> NDC_INT_BITS;
    assign sat  = (head >= den_i);
    assign res_mag = sat_q[QB] ? ((QB+1)'(1) << QB) : {1'b0, quo_q[QB]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[0] <= sat ? '0 : head;
        dvd_q[0] <= QB'({mag[NDC_INT_BITS-1:0], {FRAC_BITS{1'b0}}});
        quo_q[0] <= '0;
        sat_q[0] <= sat;
        neg_q[0] <= num[CLIPW-1];
        for (int s = 1; s <= QB; s++) begin
          logic [CLIPW:0] trial;
          logic           ge;
          trial = {rem_q[s-1], dvd_q[s-1][QB-1]};
          ge    = (trial >= {1'b0, den_q[s-1]});
          rem_q[s] <= ge ? CLIPW'(trial - {1'b0, den_q[s-1]}) : CLIPW'(trial);
          dvd_q[s] <= {dvd_q[s-1][QB-2:0], 1'b0};
          quo_q[s] <= {quo_q[s-1][QB-2:0], ge};
          sat_q[s] <= sat_q[s-1];
          neg_q[s] <= neg_q[s-1];
        end
        ndc_q <= neg_q[QB] ? -$signed({1'b0, res_mag}) : $signed({1'b0, res_mag});
      end
    end
  end

  assign tag_o   = tag_out_q;
  assign ndc_x_o = g_lane[0].ndc_q;
  assign ndc_y_o = g_lane[1].ndc_q;

endmodule

`default_nettype wire
